[design/gray_code_phase_unwrap_top_defines.svh]
// Assertion macros used by the checker file of the phase unwrap block.
// No dependencies; expects i_clk and i_rst_n in the scope of use.
`ifndef GRAY_CODE_PHASE_UNWRAP_TOP_DEFINES_SVH
`define GRAY_CODE_PHASE_UNWRAP_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define GCPU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("phase unwrap check failed");

// Next-cycle implication, disabled during reset
`define GCPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("phase unwrap check failed");

`endif

[design/gcpu_pkg.sv]
// Shared constants, types and the arctangent table of the phase unwrap block.
// No dependencies; imported by gcpu_cordic_stage, the top level and the testbench.
`timescale 1ns / 1ps

package gcpu_pkg;

    // CORDIC depth and formats
    localparam int PHASE_BITS = 16;
    localparam int SHIFT_W    = $clog2(PHASE_BITS);
    localparam int ANG_W      = 32;
    localparam int XY_W       = 42;
    localparam int PROD_W     = 23;
    localparam int CSUM_W     = 11;
    localparam int DIFF_W     = 9;
    localparam int PRE_SCALE  = 16;
    localparam int C_SCALE    = 12;

    // Field widths
    localparam int LEVEL_W    = 8;
    localparam int IDX_W      = 4;
    localparam int PHASE_W    = 16;
    localparam int UNWRAP_W   = IDX_W + PHASE_W;

    // APB register map
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;
    localparam logic [0:0] REG_GRAY_THRESHOLD = 1'b0;

    // sqrt(3) approximation in Q12
    localparam logic signed [PROD_W-1:0] SQRT3_Q12 = PROD_W'(7107);
    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [PHASE_W-1:0] HALF_PHASE = 16'h8000;

    // Keeps the top PHASE_BITS bits of the 16-bit phase
    localparam logic [PHASE_W-1:0] PHASE_MASK = (PHASE_BITS >= PHASE_W) ? 16'hFFFF :
        PHASE_W'(16'hFFFF << (PHASE_W - PHASE_BITS));

    // atan(2^-i) as a fraction of a turn, scaled by 2^32
    localparam logic [ANG_W-1:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Payload carried through the CORDIC pipeline
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [ANG_W-1:0]       ang;
        logic                   zero;
        logic [IDX_W-1:0]       idx;
    } t_cordic;

endpackage

[design/gcpu_cordic_stage.sv]
// One registered micro-rotation of the vectoring CORDIC with its handshake.
// Depends on gcpu_pkg for widths and the t_cordic payload type.
`timescale 1ns / 1ps

module gcpu_cordic_stage import gcpu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SHIFT_W-1:0] i_shift,
    input  logic [ANG_W-1:0]   i_atan,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_cordic            i_vec,
    output logic               o_valid,
    input  logic               i_ready,
    output t_cordic            o_vec
);

    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    t_cordic                n_vec;
    t_cordic                r_vec;
    logic                   r_valid;

    // Rotate toward the x axis; floor shifts
    always_comb begin
        x_in  = i_vec.x;
        y_in  = i_vec.y;
        dx    = y_in >>> i_shift;
        dy    = x_in >>> i_shift;
        n_vec = i_vec;
        if (y_in[XY_W-1]) begin
            n_vec.x   = x_in - dx;
            n_vec.y   = y_in + dy;
            n_vec.ang = i_vec.ang - i_atan;
        end else begin
            n_vec.x   = x_in + dx;
            n_vec.y   = y_in - dy;
            n_vec.ang = i_vec.ang + i_atan;
        end
    end

    // Stage moves when empty or when downstream takes its transaction
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

[design/gray_code_phase_unwrap_top.sv]
// Top level: three-step phase demodulation with Gray-code period unwrapping.
// Depends on gcpu_pkg and gcpu_cordic_stage.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+--------------------------------------
//   pixel in | i_valid / o_ready             | 3 intensities, 4 Gray plane levels
//   phase out| o_valid / i_ready             | wrapped phase, period index, unwrapped
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata (gray threshold)
//
// One transaction per cycle sustained while the output is not stalled; the registers in order:
// input arithmetic, pre-rotation, one CORDIC micro-rotation per stage, output register.
// The CORDIC chain has one shift-add stage per rotation.
// Reset clears all valid bits and the threshold register.
// Each stage accepts when empty or when its successor moves, so bubbles close up
// under an output stall and nothing is dropped or repeated.
`timescale 1ns / 1ps

module gray_code_phase_unwrap_top import gcpu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // pixel input
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [LEVEL_W-1:0]  i_intensity_zero,
    input  logic [LEVEL_W-1:0]  i_intensity_one,
    input  logic [LEVEL_W-1:0]  i_intensity_two,
    input  logic [LEVEL_W-1:0]  i_gray_level_zero,
    input  logic [LEVEL_W-1:0]  i_gray_level_one,
    input  logic [LEVEL_W-1:0]  i_gray_level_two,
    input  logic [LEVEL_W-1:0]  i_gray_level_three,
    // result output
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PHASE_W-1:0]  o_wrapped_phase,
    output logic [IDX_W-1:0]    o_period_index,
    output logic [UNWRAP_W-1:0] o_unwrapped_phase,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [LEVEL_W-1:0] r_threshold;

    // Stage 0: products and Gray decode
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] diff_w;
    logic signed [CSUM_W-1:0] csum;
    logic signed [PROD_W-1:0] n_s0_s;
    logic signed [PROD_W-1:0] n_s0_c;
    logic [IDX_W-1:0]         gbit;
    logic [IDX_W-1:0]         n_s0_idx;
    logic                     r_s0_valid;
    logic signed [PROD_W-1:0] r_s0_s;
    logic signed [PROD_W-1:0] r_s0_c;
    logic                     r_s0_zero;
    logic [IDX_W-1:0]         r_s0_idx;
    logic                     s0_ready;

    // Stage 1: pre-rotation
    logic signed [XY_W-1:0] s_w;
    logic signed [XY_W-1:0] c_w;
    t_cordic                n_pr_vec;
    t_cordic                r_pr_vec;
    logic                   r_pr_valid;
    logic                   pr_ready;

    // CORDIC chain
    t_cordic cd_vec   [0:PHASE_BITS];
    logic    cd_valid [0:PHASE_BITS];
    logic    cd_ready [0:PHASE_BITS];

    // Output register
    logic [ANG_W-1:0]   turn;
    logic [PHASE_W-1:0] n_out_phase;
    logic               r_out_valid;
    logic [PHASE_W-1:0] r_out_phase;
    logic [IDX_W-1:0]   r_out_idx;
    logic               out_ready;

    // APB: single register, pready tied high
    assign pready = 1'b1;
    assign prdata = (paddr[REG_IDX_LSB] == REG_GRAY_THRESHOLD) ?
                    PDATA_W'(r_threshold) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[REG_IDX_LSB] == REG_GRAY_THRESHOLD) begin
            r_threshold <= pwdata[LEVEL_W-1:0];
        end
    end

    // s = K*(I1-I2), c = (2*I0-I1-I2) << 12; threshold and Gray decode
    always_comb begin
        diff   = $signed({1'b0, i_intensity_one}) - $signed({1'b0, i_intensity_two});
        diff_w = PROD_W'(diff);
        n_s0_s = diff_w * SQRT3_Q12;
        csum   = $signed({2'b0, i_intensity_zero, 1'b0})
               - $signed({3'b0, i_intensity_one})
               - $signed({3'b0, i_intensity_two});
        n_s0_c = PROD_W'(csum) <<< C_SCALE;
        gbit[0] = i_gray_level_zero  > r_threshold;
        gbit[1] = i_gray_level_one   > r_threshold;
        gbit[2] = i_gray_level_two   > r_threshold;
        gbit[3] = i_gray_level_three > r_threshold;
        n_s0_idx[3] = gbit[3];
        n_s0_idx[2] = gbit[2] ^ n_s0_idx[3];
        n_s0_idx[1] = gbit[1] ^ n_s0_idx[2];
        n_s0_idx[0] = gbit[0] ^ n_s0_idx[1];
    end

    assign s0_ready = !r_s0_valid || pr_ready;
    assign o_ready  = s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && i_valid) begin
            r_s0_s    <= n_s0_s;
            r_s0_c    <= n_s0_c;
            r_s0_zero <= (n_s0_s == '0) && (n_s0_c == '0);
            r_s0_idx  <= n_s0_idx;
        end
    end

    // Scale by 2^16; fold left half-plane into right with a half-turn start
    always_comb begin
        s_w = XY_W'(r_s0_s) <<< PRE_SCALE;
        c_w = XY_W'(r_s0_c) <<< PRE_SCALE;
        n_pr_vec.zero = r_s0_zero;
        n_pr_vec.idx  = r_s0_idx;
        if (c_w[XY_W-1]) begin
            n_pr_vec.x   = -c_w;
            n_pr_vec.y   = -s_w;
            n_pr_vec.ang = HALF_TURN;
        end else begin
            n_pr_vec.x   = c_w;
            n_pr_vec.y   = s_w;
            n_pr_vec.ang = '0;
        end
    end

    assign pr_ready = !r_pr_valid || cd_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_valid <= 1'b0;
        end else if (pr_ready) begin
            r_pr_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pr_ready && r_s0_valid) begin
            r_pr_vec <= n_pr_vec;
        end
    end

    assign cd_vec[0]   = r_pr_vec;
    assign cd_valid[0] = r_pr_valid;

    // Micro-rotation stages
    for (genvar k = 0; k < PHASE_BITS; k++) begin : g_rot
        gcpu_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SHIFT_W'(k)),
            .i_atan  (ATAN_TURNS[k]),
            .i_valid (cd_valid[k]),
            .o_ready (cd_ready[k]),
            .i_vec   (cd_vec[k]),
            .o_valid (cd_valid[k+1]),
            .i_ready (cd_ready[k+1]),
            .o_vec   (cd_vec[k+1])
        );
    end

    // Phase = half turn - angle; zero vector gives a half turn
    always_comb begin
        turn = HALF_TURN - cd_vec[PHASE_BITS].ang;
        if (cd_vec[PHASE_BITS].zero) begin
            n_out_phase = HALF_PHASE;
        end else begin
            n_out_phase = turn[ANG_W-1 -: PHASE_W] & PHASE_MASK;
        end
    end

    assign out_ready            = !r_out_valid || i_ready;
    assign cd_ready[PHASE_BITS] = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= cd_valid[PHASE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && cd_valid[PHASE_BITS]) begin
            r_out_phase <= n_out_phase;
            r_out_idx   <= cd_vec[PHASE_BITS].idx;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_wrapped_phase   = r_out_phase;
    assign o_period_index    = r_out_idx;
    assign o_unwrapped_phase = {r_out_idx, r_out_phase};

endmodule

[design/gcpu_checker.sv]
// Port-level checks on the phase unwrap top level, attached by bind.
// Depends on gray_code_phase_unwrap_top_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`include "gray_code_phase_unwrap_top_defines.svh"

module gcpu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_wrapped_phase,
    input logic [3:0]  o_period_index,
    input logic [19:0] o_unwrapped_phase
);

    // Unwrapped phase is the index over the wrapped phase
    `GCPU_ASSERT_NOW(a_unwrap_concat, o_valid,
        o_unwrapped_phase == {o_period_index, o_wrapped_phase})

    // With the output empty the whole pipeline can move, so input is taken
    `GCPU_ASSERT_NOW(a_ready_when_drained, !o_valid, o_ready)

    // A stalled result transaction holds
    `GCPU_ASSERT_NEXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_wrapped_phase) && $stable(o_unwrapped_phase))

endmodule

bind gray_code_phase_unwrap_top gcpu_checker u_gcpu_checker (.*);

[tb/gray_code_phase_unwrap_top_tb.sv]
// Self-checking testbench for gray_code_phase_unwrap_top: directed pixel table, then random
// pixels over several gray thresholds, with stalls on both sides and a long output hold-off.
// Depends on gcpu_pkg and the design files of the phase unwrap block.
`timescale 1ns / 1ps

module gray_code_phase_unwrap_top_tb;
    import gcpu_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int PIPE_LATENCY   = PHASE_BITS + 3;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_DIRECTED     = 22;
    localparam int N_PHASES       = 5;
    localparam int MAX_PRINTS     = 100;

    localparam logic [PADDR_W-1:0] ADDR_GRAY_THRESHOLD = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED       = PADDR_W'(4);

    localparam logic [31:0] TURN_HALF = 32'h8000_0000;

    // atan(2^-i) in turns, scaled by 2^32
    localparam logic [31:0] TURN_ATAN [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [LEVEL_W-1:0] i0;
        logic [LEVEL_W-1:0] i1;
        logic [LEVEL_W-1:0] i2;
        logic [LEVEL_W-1:0] g0;
        logic [LEVEL_W-1:0] g1;
        logic [LEVEL_W-1:0] g2;
        logic [LEVEL_W-1:0] g3;
    } t_pixel;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [IDX_W-1:0]    idx;
        logic [UNWRAP_W-1:0] unwrapped;
    } t_phase_result;

    // fixed = 1: expected phase and index typed into the row
    typedef struct packed {
        t_pixel             px;
        logic               fixed;
        logic [PHASE_W-1:0] phase;
        logic [IDX_W-1:0]   idx;
    } t_directed_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [LEVEL_W-1:0]  i_intensity_zero;
    logic [LEVEL_W-1:0]  i_intensity_one;
    logic [LEVEL_W-1:0]  i_intensity_two;
    logic [LEVEL_W-1:0]  i_gray_level_zero;
    logic [LEVEL_W-1:0]  i_gray_level_one;
    logic [LEVEL_W-1:0]  i_gray_level_two;
    logic [LEVEL_W-1:0]  i_gray_level_three;
    logic                o_valid;
    logic                i_ready;
    logic [PHASE_W-1:0]  o_wrapped_phase;
    logic [IDX_W-1:0]    o_period_index;
    logic [UNWRAP_W-1:0] o_unwrapped_phase;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Testbench copy of the threshold register
    logic [LEVEL_W-1:0] gray_thr = '0;

    // Expectation carried alongside the pixel being offered
    logic          exp_fixed = 1'b0;
    t_phase_result exp_fixed_res = '0;

    t_phase_result phase_results_q [$];
    t_phase_result want_result;
    int            mismatch_count = 0;
    int            stall_cycles = 0;
    bit            idle_enable = 1'b1;
    bit            hold_request = 1'b0;

    gray_code_phase_unwrap_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_intensity_zero   (i_intensity_zero),
        .i_intensity_one    (i_intensity_one),
        .i_intensity_two    (i_intensity_two),
        .i_gray_level_zero  (i_gray_level_zero),
        .i_gray_level_one   (i_gray_level_one),
        .i_gray_level_two   (i_gray_level_two),
        .i_gray_level_three (i_gray_level_three),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_wrapped_phase    (o_wrapped_phase),
        .o_period_index     (o_period_index),
        .o_unwrapped_phase  (o_unwrapped_phase),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Phase demodulation and Gray decode of one pixel
    function automatic t_phase_result demodulate_pixel(input t_pixel px,
                                                       input logic [LEVEL_W-1:0] thr);
        t_phase_result      r;
        longint             x;
        longint             y;
        longint             dx;
        longint             dy;
        logic [31:0]        ang;
        logic [31:0]        turn;
        logic [31:0]        top;
        logic [PHASE_W-1:0] ph16;
        logic [3:0]         g;
        logic [3:0]         b;
        x = longint'(2 * int'(px.i0) - int'(px.i1) - int'(px.i2)) * 4096 * 65536;
        y = longint'(int'(px.i1) - int'(px.i2)) * 7107 * 65536;
        ang = '0;
        // zero vector leaves the angle at zero
        if (x != 0 || y != 0) begin
            // left half plane: flip the vector, start at a half turn
            if (x < 0) begin
                x = -x;
                y = -y;
                ang = TURN_HALF;
            end
            for (int i = 0; i < PHASE_BITS && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y < 0) begin
                    x = x - dx;
                    y = y + dy;
                    ang = ang - TURN_ATAN[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    ang = ang + TURN_ATAN[i];
                end
            end
        end
        turn = TURN_HALF - ang;
        top  = turn >> (32 - PHASE_BITS);
        if (PHASE_BITS >= PHASE_W)
            ph16 = PHASE_W'(top >> (PHASE_BITS - PHASE_W));
        else
            ph16 = PHASE_W'(top << (PHASE_W - PHASE_BITS));
        // threshold planes, then Gray to binary from the top bit down
        g = {px.g3 > thr, px.g2 > thr, px.g1 > thr, px.g0 > thr};
        b[3] = g[3];
        b[2] = g[2] ^ b[3];
        b[1] = g[1] ^ b[2];
        b[0] = g[0] ^ b[1];
        r.phase     = ph16;
        r.idx       = b;
        r.unwrapped = {b, ph16};
        return r;
    endfunction

    // Random pixel, biased toward the corner cases of the demodulator and the thresholds
    function automatic t_pixel random_pixel(input logic [LEVEL_W-1:0] thr);
        t_pixel      px;
        logic [63:0] bits;
        int          a0;
        int          lo;
        int          hi;
        int          v;
        bits = {$urandom(), $urandom()};
        px = bits[55:0];
        case ($urandom_range(0, 9))
            0: begin
                // zero vector
                px.i1 = px.i0;
                px.i2 = px.i0;
            end
            1: px.i2 = px.i1;
            2: begin
                // cosine term exactly zero
                a0 = int'(px.i0);
                lo = (2 * a0 > 255) ? 2 * a0 - 255 : 0;
                hi = (2 * a0 < 255) ? 2 * a0 : 255;
                v = $urandom_range(hi, lo);
                px.i1 = LEVEL_W'(v);
                px.i2 = LEVEL_W'(2 * a0 - v);
            end
            3: begin
                px.i0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.i1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                px.i2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        // levels straddling the threshold
        if ($urandom_range(0, 2) == 0) begin
            px.g0 = thr + LEVEL_W'($urandom_range(0, 2)) - 8'd1;
            px.g1 = thr + LEVEL_W'($urandom_range(0, 2)) - 8'd1;
            px.g2 = thr + LEVEL_W'($urandom_range(0, 2)) - 8'd1;
            px.g3 = thr + LEVEL_W'($urandom_range(0, 2)) - 8'd1;
        end
        return px;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offer one pixel, optionally after an idle burst, and wait for its transaction
    task automatic send_pixel(input t_pixel px, input logic fixed, input t_phase_result fres);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_intensity_zero   <= px.i0;
        i_intensity_one    <= px.i1;
        i_intensity_two    <= px.i2;
        i_gray_level_zero  <= px.g0;
        i_gray_level_one   <= px.g1;
        i_gray_level_two   <= px.g2;
        i_gray_level_three <= px.g3;
        exp_fixed          <= fixed;
        exp_fixed_res      <= fres;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until the pipeline has delivered everything
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (phase_results_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // unmapped index ignored, only the low byte kept
        if (addr[PADDR_W-1:REG_IDX_LSB] == REG_GRAY_THRESHOLD)
            gray_thr <= data[LEVEL_W-1:0];
        repeat (2) @(posedge i_clk);
    endtask

    // Stimulus: reset, directed table, then random phases under several thresholds
    initial begin : stimulus
        t_directed_row      rows [N_DIRECTED];
        logic [PADDR_W-1:0] ph_addr [N_PHASES];
        logic [PDATA_W-1:0] ph_data [N_PHASES];
        int                 ph_items [N_PHASES];
        t_phase_result      fres;

        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_intensity_zero   = '0;
        i_intensity_one    = '0;
        i_intensity_two    = '0;
        i_gray_level_zero  = '0;
        i_gray_level_one   = '0;
        i_gray_level_two   = '0;
        i_gray_level_three = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;

        // i0, i1, i2, g0..g3; fixed rows run at the reset threshold of zero
        rows = '{
            '{'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  }, 1'b1, 16'h8000, 4'd0 },
            '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, 16'h8000, 4'd10},
            '{'{8'd100, 8'd100, 8'd100, 8'd1,   8'd0,   8'd0,   8'd0  }, 1'b1, 16'h8000, 4'd1 },
            '{'{8'd37,  8'd37,  8'd37,  8'd9,   8'd200, 8'd0,   8'd0  }, 1'b1, 16'h8000, 4'd2 },
            '{'{8'd200, 8'd200, 8'd200, 8'd0,   8'd0,   8'd0,   8'd77 }, 1'b1, 16'h8000, 4'd15},
            '{'{8'd5,   8'd5,   8'd5,   8'd0,   8'd0,   8'd3,   8'd255}, 1'b1, 16'h8000, 4'd8 },
            '{'{8'd128, 8'd128, 8'd128, 8'd0,   8'd1,   8'd1,   8'd0  }, 1'b1, 16'h8000, 4'd4 },
            '{'{8'd255, 8'd0,   8'd0,   8'd128, 8'd64,  8'd32,  8'd16 }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd0,   8'd255, 8'd255, 8'd8,   8'd4,   8'd2,   8'd1  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd255}, 1'b0, 16'h0,    4'd0 },
            '{'{8'd0,   8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd0  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd255, 8'd255, 8'd0,   8'd170, 8'd85,  8'd170, 8'd85 }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd255, 8'd0,   8'd255, 8'd85,  8'd170, 8'd85,  8'd170}, 1'b0, 16'h0,    4'd0 },
            '{'{8'd100, 8'd200, 8'd0,   8'd1,   8'd1,   8'd1,   8'd1  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd100, 8'd0,   8'd200, 8'd2,   8'd0,   8'd2,   8'd0  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd127, 8'd254, 8'd0,   8'd254, 8'd127, 8'd0,   8'd3  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd0,   8'd1,   8'd0,   8'd0,   8'd0,   8'd1,   8'd0  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd0,   8'd0,   8'd1,   8'd0,   8'd1,   8'd0,   8'd0  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd0,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd170, 8'd85,  8'd255, 8'd170, 8'd85,  8'd255, 8'd0  }, 1'b0, 16'h0,    4'd0 },
            '{'{8'd85,  8'd170, 8'd0,   8'd1,   8'd254, 8'd128, 8'd127}, 1'b0, 16'h0,    4'd0 }
        };

        // threshold max, wide value, unmapped write, random, back to zero
        ph_addr[0] = ADDR_GRAY_THRESHOLD;  ph_data[0] = 32'h0000_00FF;
        ph_addr[1] = ADDR_GRAY_THRESHOLD;  ph_data[1] = {8'hA5, 16'($urandom()), 8'h80};
        ph_addr[2] = ADDR_UNMAPPED;        ph_data[2] = 32'h0000_0011;
        ph_addr[3] = ADDR_GRAY_THRESHOLD;  ph_data[3] = PDATA_W'($urandom_range(1, 254));
        ph_addr[4] = ADDR_GRAY_THRESHOLD;  ph_data[4] = 32'h0000_0000;
        ph_items   = '{330, 330, 320, 330, 320};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            fres.phase     = rows[r].phase;
            fres.idx       = rows[r].idx;
            fres.unwrapped = {rows[r].idx, rows[r].phase};
            send_pixel(rows[r].px, rows[r].fixed, fres);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_pipeline();
            apb_write(ph_addr[p], ph_data[p]);
            // no idling in the final phase
            idle_enable = (p != N_PHASES - 1);
            // output held off while the sender keeps offering
            if (p == 1)
                hold_request = 1'b1;
            for (int n = 0; n < ph_items[p]; n++)
                send_pixel(random_pixel(gray_thr), 1'b0, '0);
        end

        drain_pipeline();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Output side: random ready bursts, plus the long hold-off on request
    initial begin : result_sink
        i_ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (idle_enable && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Input transaction: queue the expected result
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            if (exp_fixed)
                phase_results_q.push_back(exp_fixed_res);
            else
                phase_results_q.push_back(demodulate_pixel({i_intensity_zero, i_intensity_one,
                    i_intensity_two, i_gray_level_zero, i_gray_level_one, i_gray_level_two,
                    i_gray_level_three}, gray_thr));
        end
    end

    // Output transaction: compare with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (phase_results_q.size() == 0) begin
                report_mismatch("result with no pixel pending, wrapped_phase",
                                o_wrapped_phase, -1);
            end else begin
                want_result = phase_results_q.pop_front();
                if (o_wrapped_phase !== want_result.phase)
                    report_mismatch("wrapped_phase", o_wrapped_phase, want_result.phase);
                if (o_period_index !== want_result.idx)
                    report_mismatch("period_index", o_period_index, want_result.idx);
                if (o_unwrapped_phase !== want_result.unwrapped)
                    report_mismatch("unwrapped_phase", o_unwrapped_phase,
                                    want_result.unwrapped);
            end
        end
    end

    // Watchdog: too many cycles without any transaction
    initial begin : watchdog
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/gcpu_pkg.sv
design/gcpu_cordic_stage.sv
design/gray_code_phase_unwrap_top.sv
design/gcpu_checker.sv
tb/gray_code_phase_unwrap_top_tb.sv
